[src/hp_pkg.sv]
// Shared constants and the prime table for the Halton point generator.
// Used by hp_div and halton_point_generator_top; depends on nothing.
`default_nettype none
package hp_pkg;

  localparam int unsigned IDX_W   = 49;  // skip + row * (leap + 1) stays below 2^49
  localparam int unsigned DIV_W   = 56;  // divider word, a whole number of radix steps
  localparam int unsigned FRAC_W  = 48;  // fraction bits of the weight and the sum
  localparam int unsigned OUT_SH  = 16;
  localparam int unsigned P_W     = 9;   // largest prime is 311
  localparam int unsigned STEPS   = 8;   // quotient bits per divider cycle
  localparam int unsigned PASSES  = DIV_W / STEPS;
  localparam int unsigned PASS_W  = $clog2(PASSES + 1);
  localparam int unsigned PTAB_N  = 64;
  localparam int unsigned PTAB_W  = 6;
  localparam int unsigned CNT_W   = 7;   // holds a point size up to the table length

  localparam logic [DIV_W-1:0] WT_INIT = DIV_W'(1) << FRAC_W;

  // configuration register indexes
  localparam logic [1:0] REG_DIMS = 2'd0;
  localparam logic [1:0] REG_SKIP = 2'd1;
  localparam logic [1:0] REG_LEAP = 2'd2;

  localparam logic [P_W-1:0] PRIMES [PTAB_N] = '{
    9'd2,   9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,
    9'd23,  9'd29,  9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,
    9'd59,  9'd61,  9'd67,  9'd71,  9'd73,  9'd79,  9'd83,  9'd89,
    9'd97,  9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131,
    9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173,
    9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223,
    9'd227, 9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263,
    9'd269, 9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307, 9'd311
  };

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage
`default_nettype wire

[src/hp_div.sv]
// Two-lane restoring divider by a small prime, STEPS quotient bits per cycle.
// Lane a gives quotient and remainder, lane b the quotient only. Uses hp_pkg.
`default_nettype none
module hp_div import hp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [P_W-1:0]    divisor_i,
  input  wire logic [DIV_W-1:0]  num_a_i,
  input  wire logic [DIV_W-1:0]  num_b_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [DIV_W-1:0]       quo_a_o,
  output logic [P_W-1:0]         rem_a_o,
  output logic [DIV_W-1:0]       quo_b_o
);

  logic [P_W-1:0]    div_q;
  logic [DIV_W-1:0]  sha_q, sha_d, shb_q, shb_d;
  logic [P_W-1:0]    rema_q, rema_d, remb_q, remb_d;
  logic [PASS_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;

  // STEPS long-division steps on both lanes; remainders stay below the divisor
  always_comb begin
    logic [P_W:0]     ta, tb;
    logic [DIV_W-1:0] sa, sb;
    logic [P_W-1:0]   ra, rb;
    sa = sha_q;
    sb = shb_q;
    ra = rema_q;
    rb = remb_q;
    for (int i = 0; i < STEPS; i++) begin
      ta = {ra, sa[DIV_W-1]};
      tb = {rb, sb[DIV_W-1]};
      sa = {sa[DIV_W-2:0], 1'b0};
      sb = {sb[DIV_W-2:0], 1'b0};
      if (ta >= {1'b0, div_q}) begin
        sa[0] = 1'b1;
        ra = P_W'(ta - {1'b0, div_q});
      end else begin
        ra = ta[P_W-1:0];
      end
      if (tb >= {1'b0, div_q}) begin
        sb[0] = 1'b1;
        rb = P_W'(tb - {1'b0, div_q});
      end else begin
        rb = tb[P_W-1:0];
      end
    end
    sha_d = sa;
    shb_d = sb;
    rema_d = ra;
    remb_d = rb;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = PASS_W'(PASSES);
    end else if (busy_q) begin
      cnt_d = cnt_q - PASS_W'(1);
      if (cnt_q == PASS_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q  <= divisor_i;
      sha_q  <= num_a_i;
      shb_q  <= num_b_i;
      rema_q <= '0;
      remb_q <= '0;
    end else if (busy_q) begin
      sha_q  <= sha_d;
      shb_q  <= shb_d;
      rema_q <= rema_d;
      remb_q <= remb_d;
    end
  end

  assign busy_o  = busy_q;
  assign done_o  = done_q;
  assign quo_a_o = sha_q;
  assign rem_a_o = rema_q;
  assign quo_b_o = shb_q;

endmodule
`default_nettype wire

[src/halton_point_generator_top.sv]
// Halton point generator: row in, one radical-inverse coordinate per dimension out.
// Sequencer, multiply-accumulate and output register; uses hp_pkg and hp_div.
//
// A row forms the index skip + row * (leap + 1) in a multiply and an add state. Each
// coordinate then loads its prime and weight and takes, per base-p digit of the index: a
// check, one pass of the shared divider, its done strobe and a multiply-accumulate.
// There are at most 49 digits in base 2 and fewer in larger primes, and a
// coordinate of index zero goes straight from its check to the emit state.
// A stalled output holds the emit state. No new row is taken until the last
// coordinate of the previous one is in the output register.
`default_nettype none
module halton_point_generator_top import hp_pkg::*; #(
  parameter int unsigned DIM_MAX = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // row items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] row_index
  // coordinate items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [3:0] dim_index, [35:4] coordinate, zero pad
  output logic             m_axis_tlast    // last_coord
);

  localparam int unsigned KW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_COORD = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_MAC   = 3'd6;
  localparam logic [2:0] ST_EMIT  = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [4:0]        dims_q;
  logic [31:0]       skip_q;
  logic [15:0]       leap_q;
  logic [31:0]       row_q;
  logic [IDX_W-1:0]  idx_q;
  logic [KW-1:0]     k_q;
  logic [P_W-1:0]    prime_q;
  logic [DIV_W-1:0]  num_q, w_q;
  logic [P_W-1:0]    rem_q;
  logic [FRAC_W-1:0] sum_q;
  logic              out_valid_q;
  logic [3:0]        out_dim_q;
  logic [31:0]       out_coord_q;
  logic              out_last_q;

  div_ctl_t          dctl;
  logic              dctl_busy, dctl_done;
  logic [DIV_W-1:0]  quo_a, quo_b;
  logic [P_W-1:0]    rem_a;

  logic              in_acc, out_load, out_take, last_k;
  logic [CNT_W-1:0]  count_w;
  logic [16:0]       step_w;
  logic [IDX_W-1:0]  prod_w;
  logic [P_W+FRAC_W-1:0] mac_w;

  // config port
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= 5'd1;
      skip_q <= 32'd1;
      leap_q <= 16'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DIMS: dims_q <= cfg_data_i[4:0];
        REG_SKIP: skip_q <= cfg_data_i;
        REG_LEAP: leap_q <= cfg_data_i[15:0];
        default:  ;
      endcase
    end
  end

  // point size: zero counts as one, large values saturate
  always_comb begin
    if (dims_q == 5'd0) begin
      count_w = CNT_W'(1);
    end else if (CNT_W'(dims_q) > CNT_W'(DIM_MAX)) begin
      count_w = CNT_W'(DIM_MAX);
    end else begin
      count_w = CNT_W'(dims_q);
    end
  end
  assign last_k = (CNT_W'(k_q) + CNT_W'(1)) == count_w;

  assign step_w = {1'b0, leap_q} + 17'd1;
  assign prod_w = IDX_W'(row_q) * IDX_W'(step_w);
  assign mac_w  = rem_q * w_q[FRAC_W-1:0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_take      = m_axis_tvalid && m_axis_tready;
  assign out_load      = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

  assign dctl.start = (state_q == ST_CHECK) && (num_q != '0) && (w_q != '0);
  assign dctl.busy  = dctl_busy;
  assign dctl.done  = dctl_done;

  hp_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (dctl.start),
    .divisor_i (prime_q),
    .num_a_i   (num_q),
    .num_b_i   (w_q),
    .busy_o    (dctl_busy),
    .done_o    (dctl_done),
    .quo_a_o   (quo_a),
    .rem_a_o   (rem_a),
    .quo_b_o   (quo_b)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_MUL;
      ST_MUL:   state_d = ST_ADD;
      ST_ADD:   state_d = ST_COORD;
      ST_COORD: state_d = ST_CHECK;
      ST_CHECK: state_d = dctl.start ? ST_DIV : ST_EMIT;
      ST_DIV:   if (dctl.done) state_d = ST_MAC;
      ST_MAC:   state_d = ST_CHECK;
      ST_EMIT:  if (out_load) state_d = last_k ? ST_IDLE : ST_COORD;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_ADD) begin
        k_q <= '0;
      end else if (out_load && !last_k) begin
        k_q <= k_q + KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) row_q <= s_axis_tdata;
    if (state_q == ST_MUL) idx_q <= prod_w;
    if (state_q == ST_ADD) idx_q <= idx_q + IDX_W'(skip_q);
    if (state_q == ST_COORD) begin
      prime_q <= PRIMES[PTAB_W'(k_q)];
      num_q   <= DIV_W'(idx_q);
      w_q     <= WT_INIT;
      sum_q   <= '0;
    end
    // digit j lands with weight floor(2^48 / p^(j+1))
    if (dctl.done) begin
      num_q <= quo_a;
      w_q   <= quo_b;
      rem_q <= rem_a;
    end
    if (state_q == ST_MAC) sum_q <= sum_q + mac_w[FRAC_W-1:0];
    if (out_load) begin
      out_dim_q   <= 4'(k_q);
      out_coord_q <= sum_q[FRAC_W-1:OUT_SH];
      out_last_q  <= last_k;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_coord_q, out_dim_q};
  assign m_axis_tlast  = out_last_q;

  // divider is never restarted mid-pass
  assert property (@(posedge clk_i) disable iff (!rst_ni) dctl.start |-> !dctl.busy)
    else $error("divider started while busy");
  // digit from the divider is always a valid base-p digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (rem_q < prime_q))
    else $error("digit not below prime");
  // a waiting coordinate is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && m_axis_tvalid))
    else $error("pending coordinate lost");
  // ready for a new row only once the last coordinate of the previous one is in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(s_axis_tready) && $past(state_q == ST_EMIT)) |-> m_axis_tvalid && m_axis_tlast)
    else $error("row finished without last coordinate");

endmodule
`default_nettype wire
